// File: hdl/gfq_pkg.sv
// Shared types and codes for the GPS fix quality gate.
// Used by gfq_judge and gps_fix_quality_gate_unit; no dependencies.
package gfq_pkg;

  localparam int unsigned InTdataW  = 152;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_GPS_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_ACCURACY  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STALE_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INLIER_DIST   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VALID_NEEDED  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OUTLIER_LIMIT = 3'd6;

  // decision codes
  localparam logic [3:0] DEC_DISABLED        = 4'd0;
  localparam logic [3:0] DEC_NOT_RTK         = 4'd1;
  localparam logic [3:0] DEC_INACCURATE      = 4'd2;
  localparam logic [3:0] DEC_STALE_RESTART   = 4'd3;
  localparam logic [3:0] DEC_INLIER_WAIT     = 4'd4;
  localparam logic [3:0] DEC_FIRST_VALID     = 4'd5;
  localparam logic [3:0] DEC_POS_UPDATE      = 4'd6;
  localparam logic [3:0] DEC_OUTLIER         = 4'd7;
  localparam logic [3:0] DEC_OUTLIER_RESTART = 4'd8;

  localparam logic [7:0] RUN_MAX = 8'hFF;

  typedef struct packed {
    logic        gps_enable;
    logic [15:0] max_accuracy_mm;
    logic [14:0] min_speed_mmps;
    logic [15:0] stale_timeout_ms;
    logic [15:0] inlier_distance_mm;
    logic [7:0]  valid_needed;
    logic [7:0]  outlier_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               rtk_fixed;
    logic [15:0]        accuracy_mm;
    logic signed [23:0] pos_x_mm;
    logic signed [23:0] pos_y_mm;
    logic signed [23:0] pos_z_mm;
    logic signed [15:0] motion_x_mmps;
    logic signed [15:0] motion_y_mmps;
  } fix_t;

  typedef struct packed {
    logic               qualified;
    logic               seen_any;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    logic signed [23:0] ref_z;
    logic [31:0]        ref_time;
    logic [7:0]         good_run;
    logic [7:0]         bad_run;
  } state_t;

  typedef struct packed {
    logic [3:0] decision;
    logic       orient_update;
    logic       fix_valid;
    logic [7:0] inlier_count;
    logic [7:0] reject_count;
  } res_t;

endpackage

// File: hdl/gfq_judge.sv
// Decision logic for one fix: gating, staleness, distance test, run counters, speed test.
// Purely combinational; depends on gfq_pkg.
module gfq_judge import gfq_pkg::*; (
  input  cfg_t   cfg_i,
  input  fix_t   fix_i,
  input  state_t state_i,
  output state_t state_o,
  output res_t   res_o
);

  logic [31:0]        gap;
  logic               stale;
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] sqx, sqy, sqz;
  logic [49:0]        d2;
  logic [31:0]        lim;
  logic signed [31:0] sqmx, sqmy;
  logic [31:0]        m2;
  logic [29:0]        s2;
  logic [7:0]         good_inc, bad_inc;
  state_t             nxt;
  logic [3:0]         dec;
  logic               orient;

  always_comb begin
    gap   = fix_i.now_ms - state_i.ref_time;
    stale = !state_i.seen_any || (gap > {16'd0, cfg_i.stale_timeout_ms});

    dx  = $signed({fix_i.pos_x_mm[23], fix_i.pos_x_mm}) -
          $signed({state_i.ref_x[23], state_i.ref_x});
    dy  = $signed({fix_i.pos_y_mm[23], fix_i.pos_y_mm}) -
          $signed({state_i.ref_y[23], state_i.ref_y});
    dz  = $signed({fix_i.pos_z_mm[23], fix_i.pos_z_mm}) -
          $signed({state_i.ref_z[23], state_i.ref_z});
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
    d2  = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    lim = {16'd0, cfg_i.inlier_distance_mm} * {16'd0, cfg_i.inlier_distance_mm};

    sqmx = fix_i.motion_x_mmps * fix_i.motion_x_mmps;
    sqmy = fix_i.motion_y_mmps * fix_i.motion_y_mmps;
    m2   = $unsigned(sqmx) + $unsigned(sqmy);
    s2   = {15'd0, cfg_i.min_speed_mmps} * {15'd0, cfg_i.min_speed_mmps};

    good_inc = (state_i.good_run == RUN_MAX) ? RUN_MAX : state_i.good_run + 8'd1;
    bad_inc  = (state_i.bad_run == RUN_MAX) ? RUN_MAX : state_i.bad_run + 8'd1;

    nxt    = state_i;
    orient = 1'b0;

    if (!cfg_i.gps_enable) begin
      dec = DEC_DISABLED;
    end else if (!fix_i.rtk_fixed) begin
      dec = DEC_NOT_RTK;
    end else if (fix_i.accuracy_mm > cfg_i.max_accuracy_mm) begin
      dec = DEC_INACCURATE;
    end else if (stale) begin
      nxt.qualified = 1'b0;
      nxt.good_run  = 8'd0;
      nxt.bad_run   = 8'd0;
      nxt.seen_any  = 1'b1;
      nxt.ref_x     = fix_i.pos_x_mm;
      nxt.ref_y     = fix_i.pos_y_mm;
      nxt.ref_z     = fix_i.pos_z_mm;
      nxt.ref_time  = fix_i.now_ms;
      dec = DEC_STALE_RESTART;
    end else if (d2 < {18'd0, lim}) begin
      nxt.seen_any = 1'b1;
      nxt.ref_x    = fix_i.pos_x_mm;
      nxt.ref_y    = fix_i.pos_y_mm;
      nxt.ref_z    = fix_i.pos_z_mm;
      nxt.ref_time = fix_i.now_ms;
      nxt.bad_run  = 8'd0;
      nxt.good_run = good_inc;
      if (!state_i.qualified && (good_inc > cfg_i.valid_needed)) begin
        nxt.qualified = 1'b1;
        dec = DEC_FIRST_VALID;
      end else if (state_i.qualified) begin
        orient = (m2 >= {2'd0, s2});
        dec = DEC_POS_UPDATE;
      end else begin
        dec = DEC_INLIER_WAIT;
      end
    end else if (bad_inc > cfg_i.outlier_limit) begin
      nxt.seen_any  = 1'b1;
      nxt.ref_x     = fix_i.pos_x_mm;
      nxt.ref_y     = fix_i.pos_y_mm;
      nxt.ref_z     = fix_i.pos_z_mm;
      nxt.ref_time  = fix_i.now_ms;
      nxt.qualified = 1'b0;
      nxt.good_run  = 8'd0;
      nxt.bad_run   = 8'd0;
      dec = DEC_OUTLIER_RESTART;
    end else begin
      nxt.bad_run = bad_inc;
      dec = DEC_OUTLIER;
    end

    state_o             = nxt;
    res_o.decision      = dec;
    res_o.orient_update = orient;
    res_o.fix_valid     = nxt.qualified;
    res_o.inlier_count  = nxt.good_run;
    res_o.reject_count  = nxt.bad_run;
  end

endmodule

// File: hdl/gps_fix_quality_gate_unit.sv
// Top level of the GPS fix quality gate: stream ports, config registers,
// input and result registers. Depends on gfq_pkg and gfq_judge.
//
// One result per fix, one fix per cycle sustained while the output is not
// stalled. A fix is captured in the input register, judged combinationally
// against the stored reference (three 25x25 squares, their sum and a compare)
// and lands in the result register. The state register takes the judge's
// next state whenever a fix is processed, so consecutive fixes see the
// state left by the previous one with no bubble. Config writes take effect
// on the next cycle and are meant to be made while the gate is idle.
module gps_fix_quality_gate_unit import gfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // now_ms[31:0], accuracy_mm[47:32], pos_x_mm[71:48], pos_y_mm[95:72],
  // pos_z_mm[119:96], motion_x_mmps[135:120], motion_y_mmps[151:136]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // rtk_fixed[0]
  input  logic                 s_axis_tuser,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // decision[3:0], orient_update[4], fix_valid[5], inlier_count[13:6],
  // reject_count[21:14], zero[23:22]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  cfg_t   cfg_q;
  state_t state_q, state_d;
  fix_t   in_q;
  logic   in_vld_q;
  res_t   res_d, res_q;
  logic   out_vld_q;
  logic   proc;
  logic   take;

  assign proc          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gps_enable         <= 1'b1;
      cfg_q.max_accuracy_mm    <= 16'd100;
      cfg_q.min_speed_mmps     <= 15'd10;
      cfg_q.stale_timeout_ms   <= 16'd5000;
      cfg_q.inlier_distance_mm <= 16'd5000;
      cfg_q.valid_needed       <= 8'd10;
      cfg_q.outlier_limit      <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GPS_ENABLE:    cfg_q.gps_enable         <= cfg_wdata_i[0];
        REG_MAX_ACCURACY:  cfg_q.max_accuracy_mm    <= cfg_wdata_i;
        REG_MIN_SPEED:     cfg_q.min_speed_mmps     <= cfg_wdata_i[14:0];
        REG_STALE_TIMEOUT: cfg_q.stale_timeout_ms   <= cfg_wdata_i;
        REG_INLIER_DIST:   cfg_q.inlier_distance_mm <= cfg_wdata_i;
        REG_VALID_NEEDED:  cfg_q.valid_needed       <= cfg_wdata_i[7:0];
        REG_OUTLIER_LIMIT: cfg_q.outlier_limit      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.now_ms        <= s_axis_tdata[31:0];
      in_q.accuracy_mm   <= s_axis_tdata[47:32];
      in_q.pos_x_mm      <= s_axis_tdata[71:48];
      in_q.pos_y_mm      <= s_axis_tdata[95:72];
      in_q.pos_z_mm      <= s_axis_tdata[119:96];
      in_q.motion_x_mmps <= s_axis_tdata[135:120];
      in_q.motion_y_mmps <= s_axis_tdata[151:136];
      in_q.rtk_fixed     <= s_axis_tuser;
    end
  end

  gfq_judge u_judge (
    .cfg_i   (cfg_q),
    .fix_i   (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.reject_count, res_q.inlier_count,
                          res_q.fix_valid, res_q.orient_update, res_q.decision};

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.decision == DEC_STALE_RESTART ||
                      res_q.decision == DEC_OUTLIER_RESTART)
    |-> !res_q.fix_valid && res_q.inlier_count == 8'd0 && res_q.reject_count == 8'd0)
    else $error("restart decision left run state set");

  a_orient_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.orient_update |-> res_q.decision == DEC_POS_UPDATE)
    else $error("orientation update outside position update");

  a_valid_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.decision == DEC_FIRST_VALID ||
                      res_q.decision == DEC_POS_UPDATE) |-> res_q.fix_valid)
    else $error("qualified decision without fix_valid");
`endif

endmodule
